// ===== design/tst_pkg.sv =====
// Shared types and constants for the timeout slot table.
// Used by tst_cell, tst_drain and timeout_slot_table_core; no dependencies.
package tst_pkg;

    // Operation codes carried in the op field.
    localparam logic [2:0] OP_REGISTER = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_RELOAD   = 3'd2;
    localparam logic [2:0] OP_TICK     = 3'd3;
    localparam logic [2:0] OP_COLLECT  = 3'd4;

    // Status codes carried in the status field.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    // A collect reports at most this many slots.
    localparam int          MAX_RESULTS = 16;
    localparam int          HIT_W       = 5;
    localparam logic [HIT_W-1:0] HIT_LIMIT = HIT_W'(MAX_RESULTS);

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  handler_id;
        logic [15:0] preset;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] expired_id;
        logic [3:0] slot_index;
        logic       last;
    } out_item_t;

    // Operation token that walks the row of cells.
    typedef struct packed {
        logic             valid;
        logic [2:0]       op;
        logic [7:0]       handler_id;
        logic [15:0]      preset;
        logic             found;
        logic [3:0]       slot_index;
        logic [HIT_W-1:0] hits;
    } tok_t;

    // A slot reported by a collect.
    typedef struct packed {
        logic       valid;
        logic [7:0] expired_id;
        logic [3:0] slot_index;
    } hit_t;

endpackage

// ===== design/tst_cell.sv =====
// One slot of the timeout table together with the token register at its place in the row.
// Depends on tst_pkg.
module tst_cell #(
    parameter int SLOT_NUM = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic          advance,
    input  tst_pkg::tok_t tok_in,
    output tst_pkg::tok_t tok_out,
    output tst_pkg::hit_t hit,
    output logic          tok_valid
);

    logic          used_reg, used_next;
    logic          expired_reg, expired_next;
    logic [7:0]    id_reg, id_next;
    logic [15:0]   remaining_reg, remaining_next;
    tst_pkg::tok_t tok_reg, tok_next;
    logic          act;
    logic          match;

    assign act       = tok_reg.valid && advance;
    assign match     = used_reg && (id_reg == tok_reg.handler_id) && !tok_reg.found;
    assign tok_valid = tok_reg.valid;
    assign tok_next  = load ? tok_in : tok_reg;

    always_comb begin
        used_next      = used_reg;
        expired_next   = expired_reg;
        id_next        = id_reg;
        remaining_next = remaining_reg;
        tok_out        = tok_reg;
        hit            = '0;
        if (act) begin
            case (tok_reg.op)
                tst_pkg::OP_REGISTER: begin
                    if (!tok_reg.found && !used_reg) begin
                        used_next          = 1'b1;
                        id_next            = tok_reg.handler_id;
                        remaining_next     = tok_reg.preset;
                        expired_next       = 1'b0;
                        tok_out.found      = 1'b1;
                        tok_out.slot_index = 4'(SLOT_NUM);
                    end
                end
                tst_pkg::OP_REMOVE: begin
                    if (match) begin
                        used_next          = 1'b0;
                        tok_out.found      = 1'b1;
                        tok_out.slot_index = 4'(SLOT_NUM);
                    end
                end
                tst_pkg::OP_RELOAD: begin
                    if (match) begin
                        remaining_next     = tok_reg.preset;
                        expired_next       = 1'b0;
                        tok_out.found      = 1'b1;
                        tok_out.slot_index = 4'(SLOT_NUM);
                    end
                end
                tst_pkg::OP_TICK: begin
                    if (used_reg) begin
                        if (remaining_reg != 16'd0) begin
                            remaining_next = remaining_reg - 16'd1;
                            expired_next   = 1'b0;
                        end else begin
                            expired_next = 1'b1;
                        end
                    end
                end
                tst_pkg::OP_COLLECT: begin
                    if (used_reg && expired_reg && (tok_reg.hits < tst_pkg::HIT_LIMIT)) begin
                        hit.valid      = 1'b1;
                        hit.expired_id = id_reg;
                        hit.slot_index = 4'(SLOT_NUM);
                        tok_out.hits   = tok_reg.hits + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            expired_reg   <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            used_reg      <= used_next;
            expired_reg   <= expired_next;
            tok_reg.valid <= tok_next.valid;
        end
        id_reg             <= id_next;
        remaining_reg      <= remaining_next;
        tok_reg.op         <= tok_next.op;
        tok_reg.handler_id <= tok_next.handler_id;
        tok_reg.preset     <= tok_next.preset;
        tok_reg.found      <= tok_next.found;
        tok_reg.slot_index <= tok_next.slot_index;
        tok_reg.hits       <= tok_next.hits;
    end

endmodule

// ===== design/tst_drain.sv =====
// End of the cell row: holds the last collect hit, forms the closing result and
// drives the output register. Depends on tst_pkg.
module tst_drain (
    input  logic               aclk,
    input  logic               aresetn,
    input  tst_pkg::tok_t      fin_in,
    input  tst_pkg::hit_t      hit_in,
    input  logic               m_ready,
    output logic               m_valid,
    output tst_pkg::out_item_t m_item,
    output logic               advance,
    output logic               done,
    output logic               fin_valid
);

    tst_pkg::tok_t      fin_reg;
    tst_pkg::hit_t      pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    tst_pkg::out_item_t out_reg, out_next;
    logic               out_write;

    // The whole row moves only when the output register can take a transaction.
    assign advance   = !m_valid_reg || m_ready;
    assign done      = fin_reg.valid && advance;
    assign fin_valid = fin_reg.valid;
    assign m_valid   = m_valid_reg;
    assign m_item    = out_reg;

    always_comb begin
        pend_next = pend_reg;
        out_next  = out_reg;
        out_write = 1'b0;
        if (advance && hit_in.valid) begin
            // A new hit pushes the previous one out; it was not the final one.
            if (pend_reg.valid) begin
                out_write           = 1'b1;
                out_next.status     = tst_pkg::ST_OK;
                out_next.expired_id = pend_reg.expired_id;
                out_next.slot_index = pend_reg.slot_index;
                out_next.last       = 1'b0;
            end
            pend_next = hit_in;
        end
        if (done) begin
            out_write           = 1'b1;
            out_next.status     = tst_pkg::ST_OK;
            out_next.expired_id = 8'd0;
            out_next.slot_index = 4'd0;
            out_next.last       = 1'b1;
            case (fin_reg.op) inside
                tst_pkg::OP_REGISTER: begin
                    if (fin_reg.found) begin
                        out_next.slot_index = fin_reg.slot_index;
                    end else begin
                        out_next.status = tst_pkg::ST_FULL;
                    end
                end
                tst_pkg::OP_REMOVE, tst_pkg::OP_RELOAD: begin
                    if (fin_reg.found) begin
                        out_next.slot_index = fin_reg.slot_index;
                    end else begin
                        out_next.status = tst_pkg::ST_NOT_FOUND;
                    end
                end
                tst_pkg::OP_COLLECT: begin
                    if (pend_reg.valid) begin
                        out_next.expired_id = pend_reg.expired_id;
                        out_next.slot_index = pend_reg.slot_index;
                    end else begin
                        out_next.status = tst_pkg::ST_NONE;
                    end
                    pend_next.valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (out_write) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg.valid  <= 1'b0;
            pend_reg.valid <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (advance) begin
                fin_reg.valid <= fin_in.valid;
            end
            pend_reg.valid <= pend_next.valid;
            m_valid_reg    <= m_valid_next;
        end
        if (advance) begin
            fin_reg.op         <= fin_in.op;
            fin_reg.handler_id <= fin_in.handler_id;
            fin_reg.preset     <= fin_in.preset;
            fin_reg.found      <= fin_in.found;
            fin_reg.slot_index <= fin_in.slot_index;
            fin_reg.hits       <= fin_in.hits;
        end
        pend_reg.expired_id <= pend_next.expired_id;
        pend_reg.slot_index <= pend_next.slot_index;
        out_reg             <= out_next;
    end

`ifndef ASSERT_OFF
    // A held hit exists only while its collect is still in the row.
    a_pend_in_collect: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg.valid && fin_reg.valid |-> fin_reg.op == tst_pkg::OP_COLLECT)
        else $error("held hit outside a collect");
    // The closing result of an operation always carries last.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_valid_reg && out_reg.last)
        else $error("closing result without last");
    // After a collect closes, no hit is held.
    a_pend_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !pend_reg.valid)
        else $error("hit left behind after operation end");
`endif

endmodule

// ===== design/timeout_slot_table_core.sv =====
// Top level of the timeout slot table: a row of slot cells walked by an operation token.
// Depends on tst_pkg, tst_cell and tst_drain.
//
//   Channel | Ports                       | Payload
//   input   | s_valid, s_ready, s_item    | tst_pkg::in_item_t (op, handler_id, preset)
//   result  | m_valid, m_ready, m_item    | tst_pkg::out_item_t (status, expired_id,
//           |                             |   slot_index, last)
//
// The closing result of an operation appears on m_valid once its token has visited every
// cell in turn, one cell per cycle while the row is not frozen, and then passed the closing
// stage. The next transaction can be accepted in the cycle that result appears on m_valid.
// A collect's earlier results hold up its token only where the result side stalls.
// The whole row freezes while the output register holds a transaction that is not taken.
// Reset (aresetn, synchronous, active low) frees every slot.
// Ops 5 to 7 are accepted and dropped without a result.
module timeout_slot_table_core #(
    parameter int SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tst_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output tst_pkg::out_item_t m_item
);

    tst_pkg::tok_t tok_chain [SLOTS+1];
    tst_pkg::hit_t hit_cell  [SLOTS];
    tst_pkg::hit_t hit_acc   [SLOTS+1];
    logic [SLOTS-1:0] tok_valids;
    logic          advance;
    logic          done;
    logic          fin_valid;
    logic          busy_reg, busy_next;
    logic          op_defined;
    logic          accept;

    // Only one operation is in the row at a time.
    assign s_ready    = !busy_reg;
    assign op_defined = (s_item.op == tst_pkg::OP_REGISTER) ||
                        (s_item.op == tst_pkg::OP_REMOVE)   ||
                        (s_item.op == tst_pkg::OP_RELOAD)   ||
                        (s_item.op == tst_pkg::OP_TICK)     ||
                        (s_item.op == tst_pkg::OP_COLLECT);
    assign accept     = s_valid && s_ready && op_defined;

    // The entry token starts with nothing found and no slots reported.
    always_comb begin
        tok_chain[0].valid      = accept;
        tok_chain[0].op         = s_item.op;
        tok_chain[0].handler_id = s_item.handler_id;
        tok_chain[0].preset     = s_item.preset;
        tok_chain[0].found      = 1'b0;
        tok_chain[0].slot_index = 4'd0;
        tok_chain[0].hits       = '0;
    end

    assign hit_acc[0] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic cell_load;
        // The first cell may also take a new token while the row is frozen; it is empty then.
        if (i == 0) begin : g_head
            assign cell_load = advance || accept;
        end else begin : g_body
            assign cell_load = advance;
        end

        tst_cell #(
            .SLOT_NUM (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (cell_load),
            .advance   (advance),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1]),
            .hit       (hit_cell[i]),
            .tok_valid (tok_valids[i])
        );

        // At most one cell holds the token, so the hits merge by OR.
        assign hit_acc[i+1] = tst_pkg::hit_t'(hit_acc[i] | hit_cell[i]);
    end

    tst_drain u_drain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_in    (tok_chain[SLOTS]),
        .hit_in    (hit_acc[SLOTS]),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_item    (m_item),
        .advance   (advance),
        .done      (done),
        .fin_valid (fin_valid)
    );

    always_comb begin
        if (accept) begin
            busy_next = 1'b1;
        end else if (done) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

`ifndef ASSERT_OFF
    // The token sits in at most one place along the row.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({tok_valids, fin_valid}))
        else $error("more than one operation token in the row");
    // When idle, no token is left anywhere.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (tok_valids == '0) && !fin_valid)
        else $error("token present while idle");
    // An accepted operation is in the first cell on the next edge.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && tok_valids[0])
        else $error("accepted operation did not enter the row");
`endif

endmodule

// ===== tb/timeout_slot_table_checker.sv =====
// Scoreboard for the timeout slot table: watches both channels, predicts the results
// of every accepted transaction and compares them. Depends on tst_pkg.
module timeout_slot_table_checker #(
    parameter int SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  tst_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  tst_pkg::out_item_t m_item,
    output int                 error_count,
    output int                 results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        slot_used    [SLOTS];
    logic [7:0]  slot_id      [SLOTS];
    logic [15:0] slot_count   [SLOTS];
    logic        slot_expired [SLOTS];

    tst_pkg::out_item_t owed_results[$];

    function automatic int first_used_match(input logic [7:0] id);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_id[i] == id) return i;
        end
        return -1;
    endfunction

    // Pushes the results one operation causes and updates the slot table.
    task automatic apply_slot_op(input tst_pkg::in_item_t item);
        tst_pkg::out_item_t res;
        int                 slot;
        int                 reported;
        slot     = -1;
        reported = 0;
        res      = '0;
        res.last = 1'b1;
        case (item.op) inside
            tst_pkg::OP_REGISTER: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_used[i] && slot < 0) slot = i;
                end
                if (slot < 0) begin
                    res.status = tst_pkg::ST_FULL;
                end else begin
                    slot_used[slot]    = 1'b1;
                    slot_id[slot]      = item.handler_id;
                    slot_count[slot]   = item.preset;
                    slot_expired[slot] = 1'b0;
                    res.status         = tst_pkg::ST_OK;
                    res.slot_index     = 4'(slot);
                end
                owed_results.push_back(res);
            end
            tst_pkg::OP_REMOVE, tst_pkg::OP_RELOAD: begin
                slot = first_used_match(item.handler_id);
                if (slot < 0) begin
                    res.status = tst_pkg::ST_NOT_FOUND;
                end else begin
                    if (item.op == tst_pkg::OP_REMOVE) begin
                        slot_used[slot] = 1'b0;
                    end else begin
                        slot_count[slot]   = item.preset;
                        slot_expired[slot] = 1'b0;
                    end
                    res.status     = tst_pkg::ST_OK;
                    res.slot_index = 4'(slot);
                end
                owed_results.push_back(res);
            end
            tst_pkg::OP_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i]) begin
                        if (slot_count[i] != 16'd0) begin
                            slot_count[i]   = slot_count[i] - 16'd1;
                            slot_expired[i] = 1'b0;
                        end else begin
                            slot_expired[i] = 1'b1;
                        end
                    end
                end
                res.status = tst_pkg::ST_OK;
                owed_results.push_back(res);
            end
            tst_pkg::OP_COLLECT: begin
                for (int i = 0; i < SLOTS && reported < tst_pkg::MAX_RESULTS; i++) begin
                    if (slot_used[i] && slot_expired[i]) begin
                        res.status     = tst_pkg::ST_OK;
                        res.expired_id = slot_id[i];
                        res.slot_index = 4'(i);
                        res.last       = 1'b0;
                        owed_results.push_back(res);
                        reported++;
                    end
                end
                if (reported == 0) begin
                    res.status = tst_pkg::ST_NONE;
                    owed_results.push_back(res);
                end else begin
                    owed_results[owed_results.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(input tst_pkg::out_item_t got);
        tst_pkg::out_item_t want;
        if (owed_results.size() == 0) begin
            error_count++;
            $display("%0t: extra result, expected none, got status %0d id %0d slot %0d last %0d",
                     $time, got.status, got.expired_id, got.slot_index, got.last);
        end else begin
            want = owed_results.pop_front();
            compare_field("status", int'(want.status), int'(got.status));
            compare_field("expired_id", int'(want.expired_id), int'(got.expired_id));
            compare_field("slot_index", int'(want.slot_index), int'(got.slot_index));
            compare_field("last", int'(want.last), int'(got.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i]    = 1'b0;
                slot_id[i]      = 8'd0;
                slot_count[i]   = 16'd0;
                slot_expired[i] = 1'b0;
            end
            owed_results.delete();
            results_owed <= 0;
        end else begin
            if (m_valid && m_ready) check_result(m_item);
            if (s_valid && s_ready) apply_slot_op(s_item);
            results_owed <= owed_results.size();
        end
    end

endmodule

// ===== tb/timeout_slot_table_core_tb.sv =====
// Top of the timeout slot table testbench: clock, reset, stimulus and verdict.
// Depends on tst_pkg, timeout_slot_table_core and timeout_slot_table_checker.
module timeout_slot_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 16;
    // Span of an operation from acceptance to its closing result, in cycles.
    localparam int OP_LATENCY     = SLOTS + 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 108;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tst_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tst_pkg::out_item_t m_item;

    int error_count;
    int results_owed;

    // Idling percentages for the sender and the receiver in the current phase.
    int idle_pct  = 0;
    int stall_pct = 0;

    // The stimulus asks for a long receiver hold-off by bumping hold_request;
    // the receiver process counts the stretch down on its own.
    int hold_request = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    int quiet_cycles = 0;

    // Handler ids for the current phase. Remove and reload mostly draw from this
    // small pool so that they find their slots instead of reporting not found.
    logic [7:0] id_pool [8];

    always #10 aclk = ~aclk;

    timeout_slot_table_core #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    timeout_slot_table_checker #(
        .SLOTS(SLOTS)
    ) checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .error_count (error_count),
        .results_owed(results_owed)
    );

    // Receiver: random stalls at the phase's rate, or a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            hold_left   <= 0;
            hold_served <= 0;
        end else if (hold_request != hold_served) begin
            hold_served <= hold_request;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: the run is declared hung once quiet_cycles, which counts the cycles with
    // no transaction on either channel, reaches WATCHDOG_LIMIT.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic tst_pkg::in_item_t make_item(input logic [2:0] op,
                                                    input logic [7:0] id,
                                                    input logic [15:0] preset);
        tst_pkg::in_item_t item;
        item.op         = op;
        item.handler_id = id;
        item.preset     = preset;
        return item;
    endfunction

    // Random operation: mostly well-formed traffic on the id pool with short
    // presets so that slots actually expire, with some full-range values and a
    // few undefined op codes mixed in.
    function automatic tst_pkg::in_item_t random_item();
        tst_pkg::in_item_t item;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 26)      item.op = tst_pkg::OP_REGISTER;
        else if (pick < 41) item.op = tst_pkg::OP_REMOVE;
        else if (pick < 56) item.op = tst_pkg::OP_RELOAD;
        else if (pick < 80) item.op = tst_pkg::OP_TICK;
        else if (pick < 96) item.op = tst_pkg::OP_COLLECT;
        else                item.op = 3'($urandom_range(7, 5));
        if ($urandom_range(9) == 0) item.handler_id = 8'($urandom);
        else                        item.handler_id = id_pool[3'($urandom_range(7))];
        case ($urandom_range(9))
            0:       item.preset = 16'($urandom);
            1:       item.preset = 16'hFFFF;
            default: item.preset = 16'($urandom_range(5));
        endcase
        return item;
    endfunction

    // Offers one transaction and returns at the edge where it is accepted. When
    // idling is allowed, valid drops for a random number of cycles first.
    task automatic send_item(input tst_pkg::in_item_t item, input bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. An empty table first: collect reports nothing
        // expired, a tick has no effect, and remove and reload find nothing.
        send_item(make_item(tst_pkg::OP_COLLECT, 8'h00, 16'h0000), 1'b0);
        send_item(make_item(tst_pkg::OP_TICK, 8'h00, 16'h0000), 1'b0);
        send_item(make_item(tst_pkg::OP_REMOVE, 8'h00, 16'h0000), 1'b0);
        send_item(make_item(tst_pkg::OP_RELOAD, 8'hFF, 16'hFFFF), 1'b0);

        // Fill every slot with a zero preset, the id extremes in the first two
        // slots, then one more register which must report a full table.
        for (int i = 0; i < SLOTS; i++) begin
            send_item(make_item(tst_pkg::OP_REGISTER, (i == 1) ? 8'hFF : 8'(i * 16 + i),
                                16'h0000), 1'b0);
        end
        send_item(make_item(tst_pkg::OP_REGISTER, 8'h77, 16'h1234), 1'b0);

        // One tick marks every slot expired, so collect reports the maximum
        // number of slots in a single transaction.
        send_item(make_item(tst_pkg::OP_TICK, 8'h00, 16'h0000), 1'b0);
        send_item(make_item(tst_pkg::OP_COLLECT, 8'h00, 16'h0000), 1'b0);

        // Free a slot and claim it back with the largest preset, reload the
        // first slot with the largest preset, then two undefined op codes
        // that must be swallowed without a result.
        send_item(make_item(tst_pkg::OP_REMOVE, 8'hFF, 16'h0000), 1'b0);
        send_item(make_item(tst_pkg::OP_REGISTER, 8'h5A, 16'hFFFF), 1'b0);
        send_item(make_item(tst_pkg::OP_RELOAD, 8'h00, 16'hFFFF), 1'b0);
        send_item(make_item(3'd5, 8'hFF, 16'hFFFF), 1'b0);
        send_item(make_item(3'd7, 8'h00, 16'h0000), 1'b0);
        wait_results_drained();

        // Random part in four idling phases: none, sender idle, receiver
        // stalling, and both at a light rate.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 71; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 71; end
                default: begin idle_pct = 14; stall_pct <= 14; end
            endcase
            for (int i = 0; i < 8; i++) id_pool[i] = 8'($urandom);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Early in the first phase the receiver holds off for a long
                // stretch while the sender keeps offering back to back, so
                // the row of cells freezes and the input stalls.
                if (phase == 0 && n == 10) hold_request <= hold_request + 1;
                send_item(random_item(), !(phase == 0 && n >= 10 && n < 50));
            end

            // Between phases the sender pauses until every result is back.
            wait_results_drained();
        end

        // Leave room for any stray result before the verdict.
        repeat (2 * OP_LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tst_pkg.sv
design/tst_cell.sv
design/tst_drain.sv
design/timeout_slot_table_core.sv
tb/timeout_slot_table_checker.sv
tb/timeout_slot_table_core_tb.sv
